@@ hw/rtl/cts_pkg.sv @@
// Shared types, codes and the microcode store of the cooperative thread scheduler.
package cts_pkg;

   // Request action codes.
   typedef enum logic [2:0] {
      ACT_CREATE     = 3'd0,
      ACT_GET_CUR    = 3'd1,
      ACT_GET_STATE  = 3'd2,
      ACT_SET_STATE  = 3'd3,
      ACT_YIELD_ANY  = 3'd4,
      ACT_YIELD_TO   = 3'd5,
      ACT_EXIT       = 3'd6,
      ACT_DISPOSE    = 3'd7
   } action_type;

   // Response status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_PROTOCOL  = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_HALTED    = 3'd4;

   // Thread state codes.
   localparam logic [1:0] TS_READY   = 2'd0;
   localparam logic [1:0] TS_STOPPED = 2'd1;
   localparam logic [1:0] TS_RUNNING = 2'd2;

   // Jump conditions of a control word.
   typedef enum logic [4:0] {
      C_NEVER,
      C_ALWAYS,
      C_DISPATCH,
      C_NOT_COOP,
      C_FULL,
      C_TGT_OOR,
      C_RD_TERM,
      C_ACT_GET,
      C_ACT_DISPOSE,
      C_NOT_SELFSTOP,
      C_STARG_ZERO,
      C_RD_BLOCKED,
      C_TGT_IS_CUR,
      C_SCAN_MORE,
      C_FOUND,
      C_ACT_YIELD,
      C_ID_ZERO,
      C_OUT_BUSY
   } cond_type;

   // Datapath operations of a control word.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_ADDR_SLOTS,
      OP_CREATE,
      OP_STAT_PROTOCOL,
      OP_STAT_FULL,
      OP_STAT_NOTFOUND,
      OP_HALT,
      OP_RID_CUR,
      OP_TGT_ID,
      OP_TGT_ID_OR_CUR,
      OP_TGT_STARG,
      OP_ADDR_TGT,
      OP_ADDR_CUR,
      OP_WR_NST,
      OP_DEMOTE,
      OP_PROMOTE,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_SOUT,
      OP_WR_TERM,
      OP_EXIT_KILL,
      OP_FINISH
   } op_type;

   typedef logic [5:0] upc_type;

   typedef struct packed {
      cond_type cond;
      upc_type  jmp;
      op_type   op;
   } uword_type;

   // Microprogram addresses.
   localparam upc_type U_DISPATCH = 6'd0;
   localparam upc_type U_CR0      = 6'd1;
   localparam upc_type U_CR1      = 6'd2;
   localparam upc_type U_CR2      = 6'd3;
   localparam upc_type U_CRP      = 6'd4;
   localparam upc_type U_CRF      = 6'd5;
   localparam upc_type U_GC0      = 6'd6;
   localparam upc_type U_DSP0     = 6'd7;
   localparam upc_type U_R0       = 6'd8;
   localparam upc_type U_R1       = 6'd9;
   localparam upc_type U_R2       = 6'd10;
   localparam upc_type U_R3       = 6'd11;
   localparam upc_type U_R4       = 6'd12;
   localparam upc_type U_SS0      = 6'd13;
   localparam upc_type U_SS1      = 6'd14;
   localparam upc_type U_SS2      = 6'd15;
   localparam upc_type U_PF0      = 6'd16;
   localparam upc_type U_PF1      = 6'd17;
   localparam upc_type U_SW0      = 6'd18;
   localparam upc_type U_SW1      = 6'd19;
   localparam upc_type U_SW2      = 6'd20;
   localparam upc_type U_RR0      = 6'd21;
   localparam upc_type U_RR1      = 6'd22;
   localparam upc_type U_RR2      = 6'd23;
   localparam upc_type U_MISS     = 6'd24;
   localparam upc_type U_HALT     = 6'd25;
   localparam upc_type U_NF       = 6'd26;
   localparam upc_type U_GSO      = 6'd27;
   localparam upc_type U_DSPW     = 6'd28;
   localparam upc_type U_Y5       = 6'd29;
   localparam upc_type U_Y5B      = 6'd30;
   localparam upc_type U_EX0      = 6'd31;
   localparam upc_type U_EX1      = 6'd32;
   localparam upc_type U_FIN      = 6'd33;

   function automatic uword_type mk(cond_type c, upc_type j, op_type o);
      uword_type w;
      w.cond = c;
      w.jmp  = j;
      w.op   = o;
      return w;
   endfunction

   // Control store: one word per step, jump taken when the condition holds.
   function automatic uword_type ucode_rom(upc_type a);
      uword_type w;
      unique case (a)
         // Entry: the jump target comes from the action code, or is the halt step once halted.
         U_DISPATCH: w = mk(C_DISPATCH,     U_DISPATCH, OP_NOP);
         // Create a thread in the next free slot.
         U_CR0:      w = mk(C_NOT_COOP,     U_CRP,      OP_ADDR_SLOTS);
         U_CR1:      w = mk(C_FULL,         U_CRF,      OP_NOP);
         U_CR2:      w = mk(C_ALWAYS,       U_FIN,      OP_CREATE);
         U_CRP:      w = mk(C_ALWAYS,       U_FIN,      OP_STAT_PROTOCOL);
         U_CRF:      w = mk(C_ALWAYS,       U_FIN,      OP_STAT_FULL);
         // Report the current thread.
         U_GC0:      w = mk(C_ALWAYS,       U_FIN,      OP_RID_CUR);
         // Lookup shared by get state, set state and dispose.
         U_DSP0:     w = mk(C_ALWAYS,       U_R1,       OP_TGT_ID);
         U_R0:       w = mk(C_NEVER,        U_R1,       OP_TGT_ID_OR_CUR);
         U_R1:       w = mk(C_TGT_OOR,      U_NF,       OP_ADDR_TGT);
         U_R2:       w = mk(C_RD_TERM,      U_NF,       OP_NOP);
         U_R3:       w = mk(C_ACT_GET,      U_GSO,      OP_NOP);
         U_R4:       w = mk(C_ACT_DISPOSE,  U_DSPW,     OP_NOP);
         // Set state, with a reschedule when the current thread stops itself.
         U_SS0:      w = mk(C_NEVER,        U_SS1,      OP_WR_NST);
         U_SS1:      w = mk(C_NOT_SELFSTOP, U_FIN,      OP_NOP);
         U_SS2:      w = mk(C_STARG_ZERO,   U_RR0,      OP_TGT_STARG);
         // Preferred target check.
         U_PF0:      w = mk(C_TGT_OOR,      U_MISS,     OP_ADDR_TGT);
         U_PF1:      w = mk(C_RD_BLOCKED,   U_MISS,     OP_NOP);
         // Context switch to the thread in the target register.
         U_SW0:      w = mk(C_TGT_IS_CUR,   U_FIN,      OP_ADDR_CUR);
         U_SW1:      w = mk(C_NEVER,        U_SW2,      OP_DEMOTE);
         U_SW2:      w = mk(C_ALWAYS,       U_FIN,      OP_PROMOTE);
         // Round robin scan, one slot per step.
         U_RR0:      w = mk(C_NEVER,        U_RR1,      OP_SCAN_INIT);
         U_RR1:      w = mk(C_SCAN_MORE,    U_RR1,      OP_SCAN);
         U_RR2:      w = mk(C_FOUND,        U_SW0,      OP_NOP);
         // No candidate: yields keep running, the rest halt.
         U_MISS:     w = mk(C_ACT_YIELD,    U_FIN,      OP_NOP);
         U_HALT:     w = mk(C_ALWAYS,       U_FIN,      OP_HALT);
         U_NF:       w = mk(C_ALWAYS,       U_FIN,      OP_STAT_NOTFOUND);
         U_GSO:      w = mk(C_ALWAYS,       U_FIN,      OP_SOUT);
         U_DSPW:     w = mk(C_ALWAYS,       U_FIN,      OP_WR_TERM);
         // Yield to a named thread; id zero falls back to round robin.
         U_Y5:       w = mk(C_ID_ZERO,      U_RR0,      OP_TGT_ID);
         U_Y5B:      w = mk(C_ALWAYS,       U_PF0,      OP_NOP);
         // Exit the current thread.
         U_EX0:      w = mk(C_NEVER,        U_EX1,      OP_ADDR_CUR);
         U_EX1:      w = mk(C_ALWAYS,       U_RR0,      OP_EXIT_KILL);
         // Hand the result to the output register, waiting while it is full.
         U_FIN:      w = mk(C_OUT_BUSY,     U_FIN,      OP_FINISH);
         default:    w = mk(C_ALWAYS,       U_FIN,      OP_FINISH);
      endcase
      return w;
   endfunction

   // First step of each action.
   function automatic upc_type dispatch_entry(action_type act);
      upc_type e;
      unique case (act)
         ACT_CREATE:    e = U_CR0;
         ACT_GET_CUR:   e = U_GC0;
         ACT_GET_STATE: e = U_R0;
         ACT_SET_STATE: e = U_R0;
         ACT_YIELD_ANY: e = U_RR0;
         ACT_YIELD_TO:  e = U_Y5;
         ACT_EXIT:      e = U_EX0;
         ACT_DISPOSE:   e = U_DSP0;
         default:       e = U_FIN;
      endcase
      return e;
   endfunction

endpackage

@@ hw/rtl/cts_if.sv @@
// Request and response channel interfaces of the cooperative thread scheduler.
interface cts_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [4:0] thread_id;
   logic [1:0] new_state;
   logic [4:0] suspend_target;
   logic       start_suspended;
   logic       cooperative;

   modport source (
      output valid, action, thread_id, new_state, suspend_target, start_suspended,
             cooperative,
      input  ready
   );
   modport sink (
      input  valid, action, thread_id, new_state, suspend_target, start_suspended,
             cooperative,
      output ready
   );
endinterface

interface cts_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] result_id;
   logic [1:0] state_out;
   logic [4:0] current_after;
   logic       switched;

   modport source (
      output valid, status, result_id, state_out, current_after, switched,
      input  ready
   );
   modport sink (
      input  valid, status, result_id, state_out, current_after, switched,
      output ready
   );
endinterface

@@ hw/rtl/cooperative_thread_scheduler_core.sv @@
// Top level of the cooperative thread scheduler: microcoded sequencer and datapath.
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    action, thread_id, new_state, suspend_target,
//                                       start_suspended, cooperative
//   rsp_bus   out        valid/ready    status, result_id, state_out, current_after,
//                                       switched
//
// One request at a time. The round robin scan loop of the microprogram visits one
// slot per cycle. Reset is synchronous and leaves thread 1 running, idle, with no
// response pending. A finished response sits in the output register; the next
// request is taken while it waits, and the sequencer holds in its final step
// only while the register is full and its response is not being taken.
module cooperative_thread_scheduler_core
   import cts_pkg::*;
#(
   parameter int MAX_THREADS = 16
) (
   input  logic          clock,
   input  logic          reset,
   cts_req_if.sink       req_bus,
   cts_rsp_if.source     rsp_bus
);

   localparam int RAW_W = $clog2(MAX_THREADS + 1);
   localparam int ID_W  = (RAW_W > 5) ? RAW_W : 5;
   localparam int AW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

   // Sequencer state.
   logic        busy_ff, busy_in;
   upc_type     upc_ff, upc_in;

   // Latched request.
   action_type  act_ff, act_in;
   logic [4:0]  id_ff, id_in;
   logic [1:0]  nst_ff, nst_in;
   logic [4:0]  starg_ff, starg_in;
   logic        susp_ff, susp_in;
   logic        coop_ff, coop_in;

   // Scheduler state.
   logic [ID_W-1:0] cur_ff, cur_in;
   logic [ID_W-1:0] slots_ff, slots_in;
   logic            halted_ff, halted_in;
   logic [1:0]      tstate_ff [MAX_THREADS];
   logic            term_ff [MAX_THREADS];

   // Working registers.
   logic [ID_W-1:0] tgt_ff, tgt_in;
   logic [ID_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic            found_ff, found_in;
   logic [2:0]      status_ff, status_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic [1:0]      sout_ff, sout_in;
   logic [ID_W-1:0] before_ff, before_in;

   // Output register.
   logic        ov_ff, ov_in;
   logic [2:0]  o_status_ff, o_status_in;
   logic [4:0]  o_rid_ff, o_rid_in;
   logic [1:0]  o_sout_ff, o_sout_in;
   logic [4:0]  o_cur_ff, o_cur_in;
   logic        o_sw_ff, o_sw_in;

   // Table write strobes, all at addr_ff.
   logic        st_we;
   logic [1:0]  st_wd;
   logic        tm_we;
   logic        tm_wd;

   uword_type       uw;
   logic            take;
   logic            req_fire;
   logic            out_busy;
   logic [1:0]      rd_st;
   logic            rd_term;
   logic [ID_W-1:0] id_ext;
   logic [ID_W-1:0] addr_ext;
   logic [ID_W-1:0] addr_nxt;
   logic [ID_W-1:0] tgt_m1;
   logic [ID_W-1:0] cur_m1;
   logic            tgt_oor;
   logic            cand;

   assign uw       = ucode_rom(upc_ff);
   assign req_fire = req_bus.valid && !busy_ff;
   assign out_busy = ov_ff && !rsp_bus.ready;

   // Single read port of the thread tables.
   assign rd_st    = tstate_ff[addr_ff];
   assign rd_term  = term_ff[addr_ff];

   assign id_ext   = ID_W'(id_ff);
   assign addr_ext = ID_W'(addr_ff);
   assign addr_nxt = addr_ext + ID_W'(1);
   assign tgt_m1   = tgt_ff - ID_W'(1);
   assign cur_m1   = cur_ff - ID_W'(1);
   assign tgt_oor  = (tgt_ff == '0) || (tgt_ff > slots_ff);
   // A round robin candidate is live, not stopped and not the current thread.
   assign cand     = !rd_term && (rd_st != TS_STOPPED) && (addr_nxt != cur_ff);

   // Jump condition of the current control word.
   always_comb begin
      unique case (uw.cond)
         C_NEVER:        take = 1'b0;
         C_ALWAYS:       take = 1'b1;
         C_DISPATCH:     take = 1'b1;
         C_NOT_COOP:     take = !coop_ff;
         C_FULL:         take = slots_ff >= ID_W'(MAX_THREADS);
         C_TGT_OOR:      take = tgt_oor;
         C_RD_TERM:      take = rd_term;
         C_ACT_GET:      take = act_ff == ACT_GET_STATE;
         C_ACT_DISPOSE:  take = act_ff == ACT_DISPOSE;
         C_NOT_SELFSTOP: take = (nst_ff != TS_STOPPED) || (tgt_ff != cur_ff);
         C_STARG_ZERO:   take = starg_ff == '0;
         C_RD_BLOCKED:   take = rd_term || (rd_st == TS_STOPPED);
         C_TGT_IS_CUR:   take = tgt_ff == cur_ff;
         C_SCAN_MORE:    take = !cand && ((cnt_ff + ID_W'(1)) < slots_ff);
         C_FOUND:        take = found_ff;
         C_ACT_YIELD:    take = (act_ff == ACT_YIELD_ANY) || (act_ff == ACT_YIELD_TO);
         C_ID_ZERO:      take = id_ff == '0;
         C_OUT_BUSY:     take = out_busy;
         default:        take = 1'b0;
      endcase
   end

   // Sequencer, datapath operations and request capture.
   always_comb begin
      busy_in     = busy_ff;
      upc_in      = upc_ff;
      act_in      = act_ff;
      id_in       = id_ff;
      nst_in      = nst_ff;
      starg_in    = starg_ff;
      susp_in     = susp_ff;
      coop_in     = coop_ff;
      cur_in      = cur_ff;
      slots_in    = slots_ff;
      halted_in   = halted_ff;
      tgt_in      = tgt_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      rid_in      = rid_ff;
      sout_in     = sout_ff;
      before_in   = before_ff;
      ov_in       = ov_ff;
      o_status_in = o_status_ff;
      o_rid_in    = o_rid_ff;
      o_sout_in   = o_sout_ff;
      o_cur_in    = o_cur_ff;
      o_sw_in     = o_sw_ff;
      st_we       = 1'b0;
      st_wd       = TS_READY;
      tm_we       = 1'b0;
      tm_wd       = 1'b0;

      // The response register empties on its beat.
      if (ov_ff && rsp_bus.ready) begin
         ov_in = 1'b0;
      end

      if (req_fire) begin
         act_in    = action_type'(req_bus.action);
         id_in     = req_bus.thread_id;
         nst_in    = req_bus.new_state;
         starg_in  = req_bus.suspend_target;
         susp_in   = req_bus.start_suspended;
         coop_in   = req_bus.cooperative;
         before_in = cur_ff;
         status_in = STAT_OK;
         rid_in    = '0;
         sout_in   = '0;
         busy_in   = 1'b1;
         upc_in    = U_DISPATCH;
      end else if (busy_ff) begin
         // Next step.
         if (uw.cond == C_DISPATCH) begin
            upc_in = halted_ff ? U_HALT : dispatch_entry(act_ff);
         end else if (take) begin
            upc_in = uw.jmp;
         end else begin
            upc_in = upc_ff + upc_type'(1);
         end

         unique case (uw.op)
            OP_NOP: begin
            end
            OP_ADDR_SLOTS: begin
               addr_in = slots_ff[AW-1:0];
            end
            OP_CREATE: begin
               st_we    = 1'b1;
               st_wd    = susp_ff ? TS_STOPPED : TS_READY;
               tm_we    = 1'b1;
               tm_wd    = 1'b0;
               slots_in = slots_ff + ID_W'(1);
               rid_in   = slots_ff + ID_W'(1);
            end
            OP_STAT_PROTOCOL: begin
               status_in = STAT_PROTOCOL;
            end
            OP_STAT_FULL: begin
               status_in = STAT_FULL;
            end
            OP_STAT_NOTFOUND: begin
               status_in = STAT_NOT_FOUND;
            end
            OP_HALT: begin
               status_in = STAT_HALTED;
               halted_in = 1'b1;
            end
            OP_RID_CUR: begin
               rid_in = cur_ff;
            end
            OP_TGT_ID: begin
               tgt_in = id_ext;
            end
            OP_TGT_ID_OR_CUR: begin
               tgt_in = (id_ff == '0) ? cur_ff : id_ext;
            end
            OP_TGT_STARG: begin
               tgt_in = ID_W'(starg_ff);
            end
            OP_ADDR_TGT: begin
               addr_in = tgt_m1[AW-1:0];
            end
            OP_ADDR_CUR: begin
               addr_in = cur_m1[AW-1:0];
            end
            OP_WR_NST: begin
               st_we = 1'b1;
               st_wd = nst_ff;
            end
            OP_DEMOTE: begin
               // The outgoing thread drops to ready only if live and running.
               if (!rd_term && (rd_st == TS_RUNNING)) begin
                  st_we = 1'b1;
                  st_wd = TS_READY;
               end
               addr_in = tgt_m1[AW-1:0];
            end
            OP_PROMOTE: begin
               st_we  = 1'b1;
               st_wd  = TS_RUNNING;
               cur_in = tgt_ff;
            end
            OP_SCAN_INIT: begin
               // Start one slot after the current thread, wrapping at slots_ff.
               addr_in  = (cur_ff == slots_ff) ? '0 : cur_ff[AW-1:0];
               cnt_in   = '0;
               found_in = 1'b0;
            end
            OP_SCAN: begin
               found_in = cand;
               tgt_in   = addr_nxt;
               addr_in  = (addr_nxt == slots_ff) ? '0 : addr_nxt[AW-1:0];
               cnt_in   = cnt_ff + ID_W'(1);
            end
            OP_SOUT: begin
               sout_in = rd_st;
            end
            OP_WR_TERM: begin
               tm_we = 1'b1;
               tm_wd = 1'b1;
            end
            OP_EXIT_KILL: begin
               if (!rd_term) begin
                  tm_we = 1'b1;
                  tm_wd = 1'b1;
                  st_we = 1'b1;
                  st_wd = TS_STOPPED;
               end
            end
            OP_FINISH: begin
               if (!out_busy) begin
                  busy_in     = 1'b0;
                  ov_in       = 1'b1;
                  o_status_in = status_ff;
                  o_rid_in    = rid_ff[4:0];
                  o_sout_in   = sout_ff;
                  o_cur_in    = cur_ff[4:0];
                  o_sw_in     = cur_ff != before_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control and scheduler state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         upc_ff    <= U_DISPATCH;
         ov_ff     <= 1'b0;
         cur_ff    <= ID_W'(1);
         slots_ff  <= ID_W'(1);
         halted_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         upc_ff    <= upc_in;
         ov_ff     <= ov_in;
         cur_ff    <= cur_in;
         slots_ff  <= slots_in;
         halted_ff <= halted_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      id_ff       <= id_in;
      nst_ff      <= nst_in;
      starg_ff    <= starg_in;
      susp_ff     <= susp_in;
      coop_ff     <= coop_in;
      tgt_ff      <= tgt_in;
      cnt_ff      <= cnt_in;
      addr_ff     <= addr_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rid_ff      <= rid_in;
      sout_ff     <= sout_in;
      before_ff   <= before_in;
      o_status_ff <= o_status_in;
      o_rid_ff    <= o_rid_in;
      o_sout_ff   <= o_sout_in;
      o_cur_ff    <= o_cur_in;
      o_sw_ff     <= o_sw_in;
   end

   // Thread tables: thread 1 running after reset, all others ready and live.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         if (reset) begin
            tstate_ff[i] <= (i == 0) ? TS_RUNNING : TS_READY;
            term_ff[i]   <= 1'b0;
         end else begin
            if (st_we && (addr_ff == AW'(i))) begin
               tstate_ff[i] <= st_wd;
            end
            if (tm_we && (addr_ff == AW'(i))) begin
               term_ff[i] <= tm_wd;
            end
         end
      end
   end

   assign req_bus.ready         = !busy_ff;
   assign rsp_bus.valid         = ov_ff;
   assign rsp_bus.status        = o_status_ff;
   assign rsp_bus.result_id     = o_rid_ff;
   assign rsp_bus.state_out     = o_sout_ff;
   assign rsp_bus.current_after = o_cur_ff;
   assign rsp_bus.switched      = o_sw_ff;

endmodule

@@ hw/rtl/cts_checker.sv @@
// Port-level checker of the cooperative thread scheduler and its bind.
module cts_checker
   import cts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_result_id,
   input logic [4:0] rsp_current_after,
   input logic       rsp_switched
);

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_result_id) && $stable(rsp_current_after) && $stable(rsp_switched))
      else $error("stalled response changed");

   // A thread switch only comes with a successful request.
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> rsp_status == STAT_OK)
      else $error("switch reported with error status");

   // A nonzero result id only comes with a successful request.
   a_rid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_id != '0) |-> rsp_status == STAT_OK)
      else $error("result id reported with error status");

endmodule

bind cooperative_thread_scheduler_core cts_checker u_cts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_result_id     (rsp_bus.result_id),
   .rsp_current_after (rsp_bus.current_after),
   .rsp_switched      (rsp_bus.switched)
);

@@ tb/sv/cooperative_thread_scheduler_core_tb.sv @@
// Self-checking testbench for the cooperative thread scheduler core.
module cooperative_thread_scheduler_core_tb;
   import cts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned THREAD_SLOTS = 16;
   localparam int unsigned KEEP_LIVE    = 5;
   localparam int unsigned TAIL_CYCLES  = 60;
   localparam int unsigned RUN_LIMIT_NS = 12_000_000;
   localparam int unsigned IDLE_PCT     = 19;

   // A state value outside the three named ones; it is stored and read back as given.
   localparam logic [1:0] TS_RESERVED = 2'd3;

   typedef struct {
      action_type action;
      logic [4:0] thread_id;
      logic [1:0] new_state;
      logic [4:0] suspend_target;
      logic       start_suspended;
      logic       cooperative;
   } sched_req_type;

   typedef struct {
      logic [2:0] status;
      logic [4:0] result_id;
      logic [1:0] state_out;
      logic [4:0] current_after;
      logic       switched;
   } sched_rsp_type;

   logic clock;
   logic reset;

   cts_req_if req_if ();
   cts_rsp_if rsp_if ();

   cooperative_thread_scheduler_core #(
      .MAX_THREADS(THREAD_SLOTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Scheduler shadow state, advanced once per accepted request beat.
   logic [1:0]  slot_state [THREAD_SLOTS];
   bit          slot_dead  [THREAD_SLOTS];
   int unsigned slots_taken;
   int unsigned running_id;
   bit          is_halted;

   sched_rsp_type sched_replies [$];
   int unsigned   mismatch_count;
   int unsigned   replies_seen;
   bit            calm;
   int unsigned   hold_cycles_req;

   // Clock generation.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Run limit.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   function automatic bit is_live(int unsigned id);
      return id >= 1 && id <= slots_taken && !slot_dead[id - 1];
   endfunction

   function automatic int unsigned live_count();
      int unsigned n;
      n = 0;
      for (int unsigned k = 1; k <= slots_taken; k++) begin
         if (is_live(k)) n++;
      end
      return n;
   endfunction

   // Next to run: preferred one if runnable, else 0; with none, round robin after the current.
   function automatic int unsigned choose_next(int unsigned preferred);
      int unsigned n;
      int unsigned start;
      int unsigned idx;
      n = slots_taken;
      start = 0;
      if (preferred != 0) begin
         if (is_live(preferred) && slot_state[preferred - 1] != TS_STOPPED) return preferred;
         return 0;
      end
      if (running_id >= 1 && running_id <= n) start = running_id - 1;
      for (int unsigned k = 1; k <= n; k++) begin
         idx = (start + k) % n;
         if (!slot_dead[idx] && slot_state[idx] != TS_STOPPED && idx + 1 != running_id)
            return idx + 1;
      end
      return 0;
   endfunction

   function automatic void move_to(int unsigned to);
      if (!is_live(to) || to == running_id) return;
      if (is_live(running_id) && slot_state[running_id - 1] == TS_RUNNING)
         slot_state[running_id - 1] = TS_READY;
      slot_state[to - 1] = TS_RUNNING;
      running_id = to;
   endfunction

   // Applies one request to the shadow state and returns the reply it must produce.
   function automatic sched_rsp_type run_sched_step(sched_req_type r);
      sched_rsp_type rsp;
      int unsigned   id;
      int unsigned   prior;
      int unsigned   nxt;
      rsp.status    = STAT_OK;
      rsp.result_id = '0;
      rsp.state_out = '0;
      id    = r.thread_id;
      prior = running_id;
      if (is_halted) begin
         rsp.status = STAT_HALTED;
      end else begin
         case (r.action)
            ACT_CREATE: begin
               if (!r.cooperative) begin
                  rsp.status = STAT_PROTOCOL;
               end else if (slots_taken >= THREAD_SLOTS) begin
                  rsp.status = STAT_FULL;
               end else begin
                  slot_state[slots_taken] = r.start_suspended ? TS_STOPPED : TS_READY;
                  slot_dead[slots_taken]  = 1'b0;
                  slots_taken++;
                  rsp.result_id = slots_taken[4:0];
               end
            end
            ACT_GET_CUR: begin
               rsp.result_id = running_id[4:0];
            end
            ACT_GET_STATE: begin
               if (id == 0) id = running_id;
               if (!is_live(id)) rsp.status = STAT_NOT_FOUND;
               else rsp.state_out = slot_state[id - 1];
            end
            ACT_SET_STATE: begin
               if (id == 0) id = running_id;
               if (!is_live(id)) begin
                  rsp.status = STAT_NOT_FOUND;
               end else begin
                  slot_state[id - 1] = r.new_state;
                  // The running thread stopping itself hands over or halts.
                  if (r.new_state == TS_STOPPED && id == running_id) begin
                     nxt = choose_next(r.suspend_target);
                     if (nxt != 0) begin
                        move_to(nxt);
                     end else begin
                        is_halted  = 1'b1;
                        rsp.status = STAT_HALTED;
                     end
                  end
               end
            end
            ACT_YIELD_ANY, ACT_YIELD_TO: begin
               nxt = choose_next(r.action == ACT_YIELD_TO ? id : 0);
               if (nxt != 0) move_to(nxt);
            end
            ACT_EXIT: begin
               if (is_live(running_id)) begin
                  slot_dead[running_id - 1]  = 1'b1;
                  slot_state[running_id - 1] = TS_STOPPED;
               end
               nxt = choose_next(0);
               if (nxt == 0) begin
                  is_halted  = 1'b1;
                  rsp.status = STAT_HALTED;
               end else begin
                  slot_state[nxt - 1] = TS_RUNNING;
                  running_id = nxt;
               end
            end
            default: begin
               if (!is_live(id)) rsp.status = STAT_NOT_FOUND;
               else slot_dead[id - 1] = 1'b1;
            end
         endcase
      end
      rsp.current_after = running_id[4:0];
      rsp.switched      = (running_id != prior);
      return rsp;
   endfunction

   function automatic sched_req_type make_req(action_type a, int unsigned id, logic [1:0] ns,
                                              int unsigned tgt, bit susp, bit coop);
      sched_req_type r;
      r.action          = a;
      r.thread_id       = id[4:0];
      r.new_state       = ns;
      r.suspend_target  = tgt[4:0];
      r.start_suspended = susp;
      r.cooperative     = coop;
      return r;
   endfunction

   // Random request that keeps enough threads alive and never halts the scheduler.
   function automatic sched_req_type random_request();
      sched_req_type r;
      sched_rsp_type probe;
      int unsigned   pick;
      logic [1:0]    saved_state [THREAD_SLOTS];
      bit            saved_dead  [THREAD_SLOTS];
      int unsigned   saved_slots;
      int unsigned   saved_running;
      bit            saved_halted;
      pick = $urandom_range(99, 0);
      if (pick < 8)       r.action = ACT_CREATE;
      else if (pick < 16) r.action = ACT_GET_CUR;
      else if (pick < 30) r.action = ACT_GET_STATE;
      else if (pick < 55) r.action = ACT_SET_STATE;
      else if (pick < 70) r.action = ACT_YIELD_ANY;
      else if (pick < 82) r.action = ACT_YIELD_TO;
      else if (pick < 90) r.action = ACT_EXIT;
      else                r.action = ACT_DISPOSE;
      pick = $urandom_range(99, 0);
      if (pick < 20)      r.thread_id = '0;
      else if (pick < 35) r.thread_id = running_id[4:0];
      else if (pick < 80) r.thread_id = 5'($urandom_range(slots_taken, 1));
      else                r.thread_id = 5'($urandom_range(THREAD_SLOTS, 0));
      r.new_state       = 2'($urandom_range(3, 0));
      r.suspend_target  = $urandom_range(1, 0) ? 5'd0 : 5'($urandom_range(THREAD_SLOTS, 1));
      r.start_suspended = 1'($urandom_range(1, 0));
      r.cooperative     = ($urandom_range(9, 0) != 0);
      // Kills are rationed since slots are never handed out again.
      if (r.action == ACT_EXIT && live_count() <= KEEP_LIVE) r.action = ACT_YIELD_ANY;
      if (r.action == ACT_DISPOSE && is_live(r.thread_id) && live_count() <= KEEP_LIVE)
         r.action = ACT_GET_STATE;
      // Try the request on the shadow state and back it out.
      saved_state   = slot_state;
      saved_dead    = slot_dead;
      saved_slots   = slots_taken;
      saved_running = running_id;
      saved_halted  = is_halted;
      probe = run_sched_step(r);
      slot_state  = saved_state;
      slot_dead   = saved_dead;
      slots_taken = saved_slots;
      running_id  = saved_running;
      is_halted   = saved_halted;
      if (probe.status == STAT_HALTED) r.action = ACT_YIELD_ANY;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t: reply %0d %s: got %0h, want %0h", $realtime, replies_seen, what, got, want);
      mismatch_count++;
   endtask

   // Offers one request beat and records the reply it owes once accepted.
   task automatic send_req(sched_req_type r);
      int unsigned gap;
      @(negedge clock);
      if (!calm) begin
         gap = ($urandom_range(99, 0) < 2) ? $urandom_range(40, 10) : 0;
         repeat (gap) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
         while ($urandom_range(99, 0) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid           <= 1'b1;
      req_if.action          <= r.action;
      req_if.thread_id       <= r.thread_id;
      req_if.new_state       <= r.new_state;
      req_if.suspend_target  <= r.suspend_target;
      req_if.start_suspended <= r.start_suspended;
      req_if.cooperative     <= r.cooperative;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sched_replies.insert(sched_replies.size(), run_sched_step(r));
      // The beat is taken; withdraw the offer so it is not accepted twice.
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_for_replies();
      while (sched_replies.size() != 0) @(posedge clock);
   endtask

   // Field extremes, every action and the corner cases, from the reset state.
   task automatic test_directed();
      send_req(make_req(ACT_GET_CUR,   0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_GET_STATE, 0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_GET_STATE, 2, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_CREATE,    0, TS_READY,    0, 0, 0));
      send_req(make_req(ACT_CREATE,    0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_CREATE,    0, TS_READY,    0, 1, 1));
      // Yield to a stopped thread, to itself and to a missing thread: no switch.
      send_req(make_req(ACT_YIELD_TO,  3, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_YIELD_TO,  1, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_YIELD_TO,  9, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_YIELD_ANY, 0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_SET_STATE, 3, TS_RESERVED, 0, 0, 1));
      send_req(make_req(ACT_GET_STATE, 3, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_YIELD_TO,  3, TS_READY,    0, 0, 1));
      // The running thread stops itself, first with a named successor, then round robin.
      send_req(make_req(ACT_SET_STATE, 0, TS_STOPPED,  2, 0, 1));
      send_req(make_req(ACT_SET_STATE, 0, TS_STOPPED,  0, 0, 1));
      send_req(make_req(ACT_CREATE,    0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_DISPOSE,   4, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_GET_STATE, 4, TS_READY,    0, 0, 1));
      // Disposing of the running thread leaves it current but unreachable.
      send_req(make_req(ACT_DISPOSE,   1, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_GET_STATE, 0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_GET_CUR,   0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_YIELD_ANY, 0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_SET_STATE, 3, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_EXIT,      0, TS_READY,    0, 0, 1));
      send_req(make_req(ACT_DISPOSE,   0, TS_READY,    0, 0, 1));
   endtask

   // Creates threads until the table is full, then pokes the top slot.
   task automatic test_fill_table();
      while (slots_taken < THREAD_SLOTS)
         send_req(make_req(ACT_CREATE, 0, TS_READY, 0, 1'($urandom_range(1, 0)), 1));
      send_req(make_req(ACT_CREATE,    0,            TS_READY, 0, 0, 1));
      send_req(make_req(ACT_CREATE,    0,            TS_READY, 0, 1, 0));
      send_req(make_req(ACT_SET_STATE, THREAD_SLOTS, TS_READY, 0, 0, 1));
      send_req(make_req(ACT_GET_STATE, THREAD_SLOTS, TS_READY, 0, 0, 1));
      send_req(make_req(ACT_YIELD_TO,  THREAD_SLOTS, TS_READY, 0, 0, 1));
      // Thread 3 was left ready above, so this self-stop hands over instead of halting.
      send_req(make_req(ACT_SET_STATE, 0, TS_STOPPED, 3, 0, 1));
   endtask

   task automatic test_random_mix(int unsigned count, bit no_idle);
      calm = no_idle;
      repeat (count) send_req(random_request());
      calm = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so the core backs up.
   task automatic test_output_backpressure();
      wait_for_replies();
      repeat (20) @(posedge clock);
      calm = 1'b1;
      hold_cycles_req = 300;
      repeat (10) send_req(random_request());
      calm = 1'b0;
      wait_for_replies();
   endtask

   // Drives the scheduler into its halted state by one of three routes, then probes it.
   task automatic test_halting();
      sched_req_type r;
      int unsigned   route;
      int unsigned   tgt;
      route = $urandom_range(2, 0);
      if (!is_live(running_id)) route = 0;
      tgt = 0;
      if (route == 1) begin
         for (int unsigned id = 1; id <= THREAD_SLOTS; id++) begin
            if (id != running_id && !(is_live(id) && slot_state[id - 1] != TS_STOPPED))
               tgt = id;
         end
         if (tgt == 0) route = 2;
      end
      case (route)
         0: begin
            // Exit with every other thread gone.
            for (int unsigned id = 1; id <= slots_taken; id++) begin
               if (id != running_id && is_live(id))
                  send_req(make_req(ACT_DISPOSE, id, TS_READY, 0, 0, 1));
            end
            send_req(make_req(ACT_EXIT, 0, TS_READY, 0, 0, 1));
         end
         1: begin
            // Self-stop naming a successor that cannot run.
            send_req(make_req(ACT_SET_STATE, 0, TS_STOPPED, tgt, 0, 1));
         end
         default: begin
            // Self-stop with every other thread stopped.
            for (int unsigned id = 1; id <= slots_taken; id++) begin
               if (id != running_id && is_live(id) && slot_state[id - 1] != TS_STOPPED)
                  send_req(make_req(ACT_SET_STATE, id, TS_STOPPED, 0, 0, 1));
            end
            send_req(make_req(ACT_SET_STATE, 0, TS_STOPPED, 0, 0, 1));
         end
      endcase
      repeat (8) begin
         r = random_request();
         r.action = action_type'($urandom_range(7, 0));
         send_req(r);
      end
   endtask

   // Reply receiver: random stalls, occasional long stalls and requested hold-offs.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles_req != 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
         end else if (!calm && hold_left == 0 && $urandom_range(99, 0) < 1) begin
            hold_left = $urandom_range(40, 10);
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
         end
      end
   end

   // Reply checker: each reply beat against the oldest owed reply.
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         replies_seen++;
         if (sched_replies.size() == 0) begin
            report_mismatch("arrived with nothing owed, status", 8'(rsp_if.status), 8'h00);
         end else begin
            want = sched_replies.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", 8'(rsp_if.status), 8'(want.status));
            if (rsp_if.result_id !== want.result_id)
               report_mismatch("result_id", 8'(rsp_if.result_id), 8'(want.result_id));
            if (rsp_if.state_out !== want.state_out)
               report_mismatch("state_out", 8'(rsp_if.state_out), 8'(want.state_out));
            if (rsp_if.current_after !== want.current_after)
               report_mismatch("current_after", 8'(rsp_if.current_after),
                               8'(want.current_after));
            if (rsp_if.switched !== want.switched)
               report_mismatch("switched", 8'(rsp_if.switched), 8'(want.switched));
         end
      end
   end

   // Test sequence.
   initial begin
      for (int unsigned k = 0; k < THREAD_SLOTS; k++) begin
         slot_state[k] = TS_READY;
         slot_dead[k]  = 1'b0;
      end
      slot_state[0]   = TS_RUNNING;
      slots_taken     = 1;
      running_id      = 1;
      is_halted       = 1'b0;
      mismatch_count  = 0;
      replies_seen    = 0;
      calm            = 1'b0;
      hold_cycles_req = 0;

      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.action          = ACT_GET_CUR;
      req_if.thread_id       = '0;
      req_if.new_state       = TS_READY;
      req_if.suspend_target  = '0;
      req_if.start_suspended = 1'b0;
      req_if.cooperative     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_table();
      test_random_mix(700, 1'b0);
      test_random_mix(300, 1'b1);
      test_output_backpressure();
      test_random_mix(800, 1'b0);
      test_halting();

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
